### src/atsid_pkg.sv
`timescale 1ns / 1ps

package atsid_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;

    typedef enum logic [2:0] {
        TBL_HOLD   = 3'd0,
        TBL_APPEND = 3'd1,
        TBL_INSERT = 3'd2,
        TBL_DELETE = 3'd3,
        TBL_ROTATE = 3'd4
    } tbl_op_t;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_CELL = 2'd1,
        SEL_PEND = 2'd2,
        SEL_HIT  = 2'd3
    } sel_t;

    typedef struct packed {
        logic                load;
        tbl_op_t             tbl;
        logic                step_inc;
        logic                hit_load;
        logic                pend_load;
        logic                emit;
        sel_t                sel;
        logic [STATUS_W-1:0] status;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                full;
        logic                pos_ok;
        logic                empty;
        logic                scan_done;
        logic                last_step;
        logic                cell_eq;
        logic                pend_valid;
        logic                hit;
        logic                out_free;
    } sts_t;

endpackage

### src/atsid_if.sv
`timescale 1ns / 1ps

interface atsid_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [atsid_pkg::OPCODE_W-1:0]        opcode;
    logic signed [atsid_pkg::VALUE_W-1:0]  item_value;
    logic [atsid_pkg::POS_W-1:0]           insert_position;

    modport source (output valid, output opcode, output item_value,
                    output insert_position, input ready);
    modport sink (input valid, input opcode, input item_value,
                  input insert_position, output ready);
endinterface

interface atsid_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [atsid_pkg::STATUS_W-1:0]        status;
    logic [atsid_pkg::SLOT_W-1:0]          slot_number;
    logic signed [atsid_pkg::VALUE_W-1:0]  entry_value;
    logic [atsid_pkg::SLOT_W-1:0]          entry_count;
    logic                                  last_result;

    modport source (output valid, output status, output slot_number,
                    output entry_value, output entry_count,
                    output last_result, input ready);
    modport sink (input valid, input status, input slot_number,
                  input entry_value, input entry_count,
                  input last_result, output ready);
endinterface

### src/atsid_dp.sv
`timescale 1ns / 1ps

module atsid_dp #(
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [atsid_pkg::OPCODE_W-1:0]       opcode,
    input  logic signed [atsid_pkg::VALUE_W-1:0] item_value,
    input  logic [atsid_pkg::POS_W-1:0]          insert_position,
    input  atsid_pkg::cmd_t                      cmd,
    output atsid_pkg::sts_t                      sts,
    atsid_out_if.source                          out_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = ((CNT_W > atsid_pkg::POS_W) ? CNT_W : atsid_pkg::POS_W) + 1;

    logic [atsid_pkg::VALUE_W-1:0]  cell_reg [DEPTH];
    logic [atsid_pkg::VALUE_W-1:0]  cell_next [DEPTH];
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [atsid_pkg::OPCODE_W-1:0] op_reg;
    logic [atsid_pkg::VALUE_W-1:0]  key_reg;
    logic [atsid_pkg::POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]               step_reg;
    logic                           hit_reg;
    logic [IDX_W-1:0]               hit_idx_reg;
    logic                           pend_valid_reg;
    logic [CNT_W-1:0]               pend_slot_reg;
    logic                           out_valid_reg;
    logic [atsid_pkg::STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]               out_slot_reg;
    logic [atsid_pkg::VALUE_W-1:0]  out_value_reg;
    logic [CNT_W-1:0]               out_count_reg;
    logic                           out_last_reg;
    logic [CNT_W-1:0]               slot_next;
    logic [atsid_pkg::VALUE_W-1:0]  value_next;
    logic                           out_free;

    // shift cells: each cell sees only its neighbors and cell 0
    genvar k;
    for (k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [atsid_pkg::VALUE_W-1:0] up_val;
        logic [atsid_pkg::VALUE_W-1:0] dn_val;
        logic at_cnt;
        logic below_cnt;
        logic ins_here;
        logic ins_move;
        logic del_move;
        logic rot_wrap;

        if (k == DEPTH - 1)
        begin : g_top
            assign up_val = cell_reg[k];
        end
        else
        begin : g_mid
            assign up_val = cell_reg[k+1];
        end
        if (k == 0)
        begin : g_bot
            assign dn_val = cell_reg[k];
        end
        else
        begin : g_low
            assign dn_val = cell_reg[k-1];
        end

        assign at_cnt    = CNT_W'(k) == count_reg;
        assign below_cnt = CNT_W'(k) < count_reg;
        assign ins_here  = CW'(k + 1) == CW'(pos_reg);
        assign ins_move  = (CW'(k + 1) > CW'(pos_reg)) && (CNT_W'(k) <= count_reg);
        assign del_move  = (IDX_W'(k) >= hit_idx_reg) && (CNT_W'(k + 1) < count_reg);
        assign rot_wrap  = CNT_W'(k + 1) == count_reg;

        always_comb
        begin
            cell_next[k] = cell_reg[k];
            unique case (cmd.tbl)
                atsid_pkg::TBL_APPEND:
                begin
                    if (at_cnt)
                        cell_next[k] = key_reg;
                end
                atsid_pkg::TBL_INSERT:
                begin
                    if (ins_here)
                        cell_next[k] = key_reg;
                    else if (ins_move)
                        cell_next[k] = dn_val;
                end
                atsid_pkg::TBL_DELETE:
                begin
                    if (del_move)
                        cell_next[k] = up_val;
                end
                atsid_pkg::TBL_ROTATE:
                begin
                    if (below_cnt)
                        cell_next[k] = rot_wrap ? cell_reg[0] : up_val;
                end
                default:
                begin
                    cell_next[k] = cell_reg[k];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            cell_reg[k] <= cell_next[k];
        end
    end

    always_comb
    begin
        unique case (cmd.tbl)
            atsid_pkg::TBL_APPEND,
            atsid_pkg::TBL_INSERT: count_next = count_reg + CNT_W'(1);
            atsid_pkg::TBL_DELETE: count_next = count_reg - CNT_W'(1);
            default:               count_next = count_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.sel)
            atsid_pkg::SEL_CELL:
            begin
                slot_next  = step_reg + CNT_W'(1);
                value_next = cell_reg[0];
            end
            atsid_pkg::SEL_PEND:
            begin
                slot_next  = pend_slot_reg;
                value_next = key_reg;
            end
            atsid_pkg::SEL_HIT:
            begin
                slot_next  = CNT_W'(hit_idx_reg) + CNT_W'(1);
                value_next = key_reg;
            end
            default:
            begin
                slot_next  = '0;
                value_next = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            step_reg       <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                step_reg       <= '0;
                hit_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step_inc)
                    step_reg <= step_reg + CNT_W'(1);
                if (cmd.hit_load)
                    hit_reg <= 1'b1;
                if (cmd.pend_load)
                    pend_valid_reg <= 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= item_value;
            pos_reg <= insert_position;
        end
        if (cmd.hit_load)
            hit_idx_reg <= step_reg[IDX_W-1:0];
        if (cmd.pend_load)
            pend_slot_reg <= step_reg + CNT_W'(1);
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_slot_reg   <= slot_next;
            out_value_reg  <= value_next;
            out_count_reg  <= count_next;
            out_last_reg   <= cmd.last;
        end
    end

    assign sts.op         = op_reg;
    assign sts.full       = count_reg == CNT_W'(DEPTH);
    assign sts.pos_ok     = (pos_reg != '0)
                          && (CW'(pos_reg) <= CW'(count_reg) + CW'(1));
    assign sts.empty      = count_reg == '0;
    assign sts.scan_done  = step_reg == count_reg;
    assign sts.last_step  = step_reg + CNT_W'(1) == count_reg;
    assign sts.cell_eq    = cell_reg[0] == key_reg;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.hit        = hit_reg;
    assign sts.out_free   = out_free;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.slot_number = atsid_pkg::SLOT_W'(out_slot_reg);
    assign out_ch.entry_value = out_value_reg;
    assign out_ch.entry_count = atsid_pkg::SLOT_W'(out_count_reg);
    assign out_ch.last_result = out_last_reg;

endmodule

### src/atsid_ctrl.sv
`timescale 1ns / 1ps

module atsid_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  atsid_pkg::sts_t sts,
    output atsid_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.op)
                    atsid_pkg::OP_APPEND:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                            if (sts.full)
                                cmd.status = atsid_pkg::ST_FULL;
                            else
                            begin
                                cmd.tbl    = atsid_pkg::TBL_APPEND;
                                cmd.status = atsid_pkg::ST_DONE;
                            end
                        end
                    end
                    atsid_pkg::OP_INSERT:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                            if (sts.full)
                                cmd.status = atsid_pkg::ST_FULL;
                            else if (!sts.pos_ok)
                                cmd.status = atsid_pkg::ST_BADPOS;
                            else
                            begin
                                cmd.tbl    = atsid_pkg::TBL_INSERT;
                                cmd.status = atsid_pkg::ST_DONE;
                            end
                        end
                    end
                    atsid_pkg::OP_SEARCH,
                    atsid_pkg::OP_DELETE,
                    atsid_pkg::OP_LIST:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        // unused opcodes give a single done item
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.status = atsid_pkg::ST_DONE;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                // the table rotates once per step so cell 0 walks all entries
                if (!sts.scan_done)
                begin
                    if (sts.op == atsid_pkg::OP_LIST)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.tbl      = atsid_pkg::TBL_ROTATE;
                            cmd.step_inc = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.sel      = atsid_pkg::SEL_CELL;
                            cmd.status   = atsid_pkg::ST_LISTED;
                            cmd.last     = sts.last_step;
                        end
                    end
                    else if (sts.op == atsid_pkg::OP_SEARCH)
                    begin
                        // a match is held back until the next one shows up or the scan ends
                        if (!(sts.cell_eq && sts.pend_valid) || sts.out_free)
                        begin
                            cmd.tbl      = atsid_pkg::TBL_ROTATE;
                            cmd.step_inc = 1'b1;
                            if (sts.cell_eq)
                            begin
                                cmd.pend_load = 1'b1;
                                if (sts.pend_valid)
                                begin
                                    cmd.emit   = 1'b1;
                                    cmd.sel    = atsid_pkg::SEL_PEND;
                                    cmd.status = atsid_pkg::ST_MATCH;
                                end
                            end
                        end
                    end
                    else
                    begin
                        cmd.tbl      = atsid_pkg::TBL_ROTATE;
                        cmd.step_inc = 1'b1;
                        if (sts.cell_eq && !sts.hit)
                            cmd.hit_load = 1'b1;
                    end
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                    cmd.last   = 1'b1;
                    if (sts.op == atsid_pkg::OP_LIST)
                    begin
                        cmd.emit   = sts.empty;
                        cmd.status = atsid_pkg::ST_DONE;
                    end
                    else if (sts.op == atsid_pkg::OP_SEARCH)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.pend_valid)
                        begin
                            cmd.sel    = atsid_pkg::SEL_PEND;
                            cmd.status = atsid_pkg::ST_MATCH;
                        end
                        else
                            cmd.status = atsid_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        if (sts.hit)
                        begin
                            cmd.tbl    = atsid_pkg::TBL_DELETE;
                            cmd.sel    = atsid_pkg::SEL_HIT;
                            cmd.status = atsid_pkg::ST_DONE;
                        end
                        else
                            cmd.status = atsid_pkg::ST_NOTFOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/array_table_search_insert_delete_top.sv
// append, insert and unused opcodes load their result from the exec state once out is free
// search, delete and list step once per stored entry, set by the rotating shift-cell
// table that shows one entry at cell 0 per cycle unless a result waits for the output
// a new item is taken only in idle, so it waits for the last one and any output stalls
// reset: count and control clear at once; table contents stay undefined until written
`timescale 1ns / 1ps

module array_table_search_insert_delete_top #(
    parameter int DEPTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    atsid_in_if.sink  in_ch,
    atsid_out_if.source out_ch
);

    atsid_pkg::cmd_t cmd;
    atsid_pkg::sts_t sts;
    logic            in_ready;

    assign in_ch.ready = in_ready;

    atsid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atsid_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .opcode          (in_ch.opcode),
        .item_value      (in_ch.item_value),
        .insert_position (in_ch.insert_position),
        .cmd             (cmd),
        .sts             (sts),
        .out_ch          (out_ch)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken again while an item is in progress");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an item not yet taken");

    a_multi_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last_result) |->
            (out_ch.status == atsid_pkg::ST_MATCH || out_ch.status == atsid_pkg::ST_LISTED))
        else $error("non-final result with a single-result status");
`endif

endmodule
